// ===== hw/rtl/mbps_pkg.sv =====
package mbps_pkg;

    // Configuration port geometry: six registers at 8-byte spacing.
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;
    localparam int IDX_W    = 3;
    localparam int PAT_REGS = 4;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_PAT0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_PAT1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_PAT2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_PAT3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_CARE = 3'd4;
    localparam logic [IDX_W-1:0] REG_LEN  = 3'd5;

    // Field widths fixed by the register map.
    localparam int LEN_W     = 6;
    localparam int CARE_W    = 32;
    localparam int PAT_IDX_W = 5;
    localparam int COUNT_W   = 32;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 32'hFFFF_FFFF;

    // Length information handed from the register file to the scanner.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             zero_len;
    } match_ctrl_t;

endpackage

// ===== hw/rtl/mbps_in_if.sv =====
interface mbps_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_image;

    modport source (output valid, output data_byte, output end_of_image, input ready);
    modport sink (input valid, input data_byte, input end_of_image, output ready);

endinterface

// ===== hw/rtl/mbps_out_if.sv =====
interface mbps_out_if;

    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink (input valid, input found, input match_offset, output ready);

endinterface

// ===== hw/rtl/mbps_cfg.sv =====
module mbps_cfg
    import mbps_pkg::*;
#(
    parameter int PATTERN_MAX = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    output logic [PATTERN_MAX*8-1:0]  aligned_pattern,
    output logic [PATTERN_MAX-1:0]    aligned_care,
    output match_ctrl_t               ctrl
);

    logic [PAT_REGS-1:0][DATA_W-1:0] pat_reg;
    logic [CARE_W-1:0]               care_reg;
    logic [LEN_W-1:0]                len_reg;
    logic [PAT_REGS*DATA_W-1:0]      pat_flat;
    logic [IDX_W-1:0]                reg_idx;
    logic                            wr_en;
    logic [LEN_W-1:0]                len_eff;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:3];
    assign wr_en   = psel & penable & pwrite;

    // Register writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg  <= '0;
            care_reg <= '0;
            len_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PAT0: pat_reg[0] <= pwdata;
                REG_PAT1: pat_reg[1] <= pwdata;
                REG_PAT2: pat_reg[2] <= pwdata;
                REG_PAT3: pat_reg[3] <= pwdata;
                REG_CARE: care_reg   <= pwdata[CARE_W-1:0];
                REG_LEN:  len_reg    <= pwdata[LEN_W-1:0];
                default:  ;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        case (reg_idx)
            REG_PAT0: prdata = pat_reg[0];
            REG_PAT1: prdata = pat_reg[1];
            REG_PAT2: prdata = pat_reg[2];
            REG_PAT3: prdata = pat_reg[3];
            REG_CARE: prdata = DATA_W'(care_reg);
            REG_LEN:  prdata = DATA_W'(len_reg);
            default:  prdata = '0;
        endcase
    end

    // A length above the window size is clamped to it.
    assign len_eff = (len_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_reg;
    assign ctrl.len      = len_eff;
    assign ctrl.zero_len = (len_eff == '0);
    assign pat_flat      = pat_reg;

    // Reorder the pattern so that position k lines up with the byte k steps
    // back from the newest one. Positions beyond the length never care.
    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_align
        logic [LEN_W-1:0]     j_full;
        logic [PAT_IDX_W-1:0] j_idx;

        assign j_full = len_eff - LEN_W'(k + 1);
        assign j_idx  = j_full[PAT_IDX_W-1:0];
        assign aligned_pattern[k*8 +: 8] = pat_flat[{j_idx, 3'b000} +: 8];
        assign aligned_care[k] = (LEN_W'(k) < len_eff) & care_reg[j_idx];
    end

endmodule

// ===== hw/rtl/mbps_match.sv =====
module mbps_match #(
    parameter int PATTERN_MAX = 32
)
(
    input  logic [7:0]                 cur_byte,
    input  logic [(PATTERN_MAX-1)*8-1:0] window,
    input  logic [PATTERN_MAX*8-1:0]   aligned_pattern,
    input  logic [PATTERN_MAX-1:0]     aligned_care,
    output logic                       window_hit
);

    logic [PATTERN_MAX-1:0] pos_ok;

    // Position 0 is the current byte, position k the byte k steps back.
    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cmp
        logic [7:0] d;

        if (k == 0)
        begin : g_cur
            assign d = cur_byte;
        end
        else
        begin : g_past
            assign d = window[(k-1)*8 +: 8];
        end

        assign pos_ok[k] = ~aligned_care[k] | (d == aligned_pattern[k*8 +: 8]);
    end

    assign window_hit = &pos_ok;

endmodule

// ===== hw/rtl/masked_byte_pattern_scan.sv =====
// A byte accepted on byte_in that gives a result passes the input register, then the result register.
// Throughput: one byte per cycle; all window positions are compared in parallel between the
// input register and the result register, and a result word held back stalls byte_in when both are full.
// Reset (rst_n, asynchronous, active low) clears the configuration registers, the byte
// window, the byte count and the matched flag; the last byte of an image also
// clears the scan state but keeps the configuration.
module masked_byte_pattern_scan
    import mbps_pkg::*;
#(
    parameter int PATTERN_MAX = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    mbps_in_if.sink           byte_in,
    mbps_out_if.source        result_out
);

    localparam int WIN_DEPTH = PATTERN_MAX - 1;

    logic [PATTERN_MAX*8-1:0] aligned_pattern;
    logic [PATTERN_MAX-1:0]   aligned_care;
    match_ctrl_t              ctrl;

    logic                     s1_valid_reg;
    logic [7:0]               s1_byte_reg;
    logic                     s1_eoi_reg;

    logic [WIN_DEPTH-1:0][7:0] window_reg;
    logic [COUNT_W-1:0]       bytes_seen_reg;
    logic                     matched_reg;

    logic                     out_valid_reg;
    logic                     out_found_reg;
    logic [COUNT_W-1:0]       out_offset_reg;

    logic                     advance;
    logic                     s1_take;
    logic                     window_hit;
    logic                     hit;
    logic                     res_valid;
    logic [LEN_W-1:0]         len_m1;
    logic [COUNT_W-1:0]       start;

    mbps_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .aligned_pattern (aligned_pattern),
        .aligned_care    (aligned_care),
        .ctrl            (ctrl)
    );

    mbps_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .cur_byte        (s1_byte_reg),
        .window          (window_reg),
        .aligned_pattern (aligned_pattern),
        .aligned_care    (aligned_care),
        .window_hit      (window_hit)
    );

    // Handshake: the input register moves on whenever the result slot is free.
    assign advance       = ~out_valid_reg | result_out.ready;
    assign s1_take       = s1_valid_reg & advance;
    assign byte_in.ready = ~s1_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (byte_in.valid && byte_in.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_take)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            s1_byte_reg <= byte_in.data_byte;
            s1_eoi_reg  <= byte_in.end_of_image;
        end
    end

    // Match decision. A match needs enough bytes seen for the full length,
    // and nothing is tested once the count has saturated.
    assign len_m1 = ctrl.len - LEN_W'(1);
    assign start  = bytes_seen_reg - COUNT_W'(len_m1);
    assign hit    = ~matched_reg & (bytes_seen_reg != COUNT_LIMIT)
                    & (ctrl.zero_len
                       | ((bytes_seen_reg >= COUNT_W'(len_m1)) & window_hit));
    assign res_valid = hit | (s1_eoi_reg & ~matched_reg);

    // Scan state: byte window, saturating count and matched flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            bytes_seen_reg <= '0;
            matched_reg    <= 1'b0;
        end
        else if (s1_take)
        begin
            if (s1_eoi_reg)
            begin
                window_reg     <= '0;
                bytes_seen_reg <= '0;
                matched_reg    <= 1'b0;
            end
            else
            begin
                for (int i = WIN_DEPTH - 1; i > 0; i--)
                begin
                    window_reg[i] <= window_reg[i-1];
                end
                window_reg[0] <= s1_byte_reg;
                if (bytes_seen_reg != COUNT_LIMIT)
                begin
                    bytes_seen_reg <= bytes_seen_reg + COUNT_W'(1);
                end
                matched_reg <= matched_reg | hit;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_take && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && res_valid)
        begin
            out_found_reg  <= hit;
            out_offset_reg <= (hit && !ctrl.zero_len) ? start : '0;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.found        = out_found_reg;
    assign result_out.match_offset = out_offset_reg;

`ifndef NO_ASSERTIONS
    // A not-found word always carries a zero offset.
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_offset_reg == '0))
        else $error("not-found word with nonzero offset");

    // The last byte of an image leaves the scan state cleared.
    a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_take && s1_eoi_reg) |=> (bytes_seen_reg == '0 && !matched_reg))
        else $error("scan state not cleared after end of image");

    // Once a match has been reported, no further match is raised in the image.
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        matched_reg |-> !hit)
        else $error("second match in one image");
`endif

endmodule

// ===== dv/mbps_scan_checker.sv =====
`timescale 1ns / 1ps

module mbps_scan_checker
    import mbps_pkg::*;
#(
    parameter int PATTERN_MAX = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    mbps_in_if                byte_mon,
    mbps_out_if               result_mon,
    output int                errors,
    output int                pending
);

    localparam int ADDR_LSB   = $clog2(DATA_W / 8);
    localparam int WINDOW     = PATTERN_MAX - 1;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] offset;
    } scan_result_t;

    // Shadow copy of the register file.
    logic [DATA_W-1:0] pat_words [PAT_REGS];
    logic [CARE_W-1:0] care;
    logic [LEN_W-1:0]  len_reg;

    // Shadow copy of the scan state for the current image.
    logic [7:0]         history [WINDOW];
    logic [COUNT_W-1:0] byte_count;
    logic               matched;

    // Results owed by the block, oldest first.
    scan_result_t results_due [$];
    scan_result_t want;

    // Clears the window, the byte count and the matched flag.
    function automatic void restart_image();
        foreach (history[i]) history[i] = '0;
        byte_count = '0;
        matched    = 1'b0;
    endfunction

    // Predicts the result, if any, of one accepted word and advances the scan state.
    function automatic void scan_byte(input logic [7:0] cur, input logic last);
        int           span;
        int           back;
        bit           hit;
        logic [7:0]   seen;
        scan_result_t res;
        span = (len_reg > LEN_W'(PATTERN_MAX)) ? PATTERN_MAX : int'(len_reg);
        hit  = 1'b0;
        res  = '0;
        if (!matched && byte_count != COUNT_LIMIT) begin
            if (span == 0) begin
                hit = 1'b1;
            end
            else if (longint'(byte_count) + 1 >= span) begin
                // Every cared position of the window ending at this byte must agree.
                hit = 1'b1;
                for (int j = 0; j < span; j++) begin
                    back = span - 1 - j;
                    if (back == 0)
                        seen = cur;
                    else
                        seen = history[back - 1];
                    if (care[j] && seen != pat_words[j / 8][(j % 8) * 8 +: 8])
                        hit = 1'b0;
                end
                res.offset = COUNT_W'(longint'(byte_count) + 1 - span);
            end
            if (hit) begin
                matched   = 1'b1;
                res.found = 1'b1;
                results_due.push_back(res);
            end
        end
        // The last byte reports not-found if nothing matched, then clears the scan.
        if (last) begin
            if (!matched)
                results_due.push_back(scan_result_t'('0));
            restart_image();
        end
        else begin
            for (int i = WINDOW - 1; i > 0; i--)
                history[i] = history[i - 1];
            history[0] = cur;
            if (byte_count != COUNT_LIMIT)
                byte_count = byte_count + 1'b1;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            foreach (pat_words[i]) pat_words[i] = '0;
            care    = '0;
            len_reg = '0;
            restart_image();
            results_due.delete();
            errors  = 0;
            pending = 0;
        end
        else begin
            // Register writes; indexes past the register list are ignored.
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:ADDR_LSB])
                    REG_PAT0: pat_words[0] = pwdata;
                    REG_PAT1: pat_words[1] = pwdata;
                    REG_PAT2: pat_words[2] = pwdata;
                    REG_PAT3: pat_words[3] = pwdata;
                    REG_CARE: care = pwdata[CARE_W-1:0];
                    REG_LEN:  len_reg = pwdata[LEN_W-1:0];
                    default:  ;
                endcase
            end

            if (byte_mon.valid && byte_mon.ready)
                scan_byte(byte_mon.data_byte, byte_mon.end_of_image);

            // Each result word is compared with the oldest prediction.
            if (result_mon.valid && result_mon.ready) begin
                if (results_due.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("%0t: unexpected result found=%0d offset=%0d", $time,
                                 result_mon.found, result_mon.match_offset);
                end
                else begin
                    want = results_due.pop_front();
                    if (want.found !== result_mon.found ||
                        want.offset !== result_mon.match_offset) begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $display("%0t: result mismatch: expected found=%0d offset=%0d, got found=%0d offset=%0d",
                                     $time, want.found, want.offset,
                                     result_mon.found, result_mon.match_offset);
                    end
                end
            end

            pending = results_due.size();
        end
    end

endmodule

// ===== dv/tb_masked_byte_pattern_scan.sv =====
`timescale 1ns / 1ps

module tb_masked_byte_pattern_scan;
    import mbps_pkg::*;

    localparam int PATTERN_MAX  = 32;
    localparam int ADDR_LSB     = $clog2(DATA_W / 8);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_WORDS  = 50;
    localparam int PHASES       = 12;
    localparam int HOLD_PHASE   = 8;
    localparam int PAUSE_PHASE  = 5;

    // Addresses past the register list; writes there must not land anywhere.
    localparam logic [IDX_W-1:0] REG_SPARE0 = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE1 = 3'd7;

    // ASCII 'x', a byte the pattern and the images use often.
    localparam logic [7:0]        CHAR_X = 8'h78;
    localparam logic [DATA_W-1:0] X_FILL = {8{CHAR_X}};

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int errors;
    int pending;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;
    int hold_left;

    // Copy of the configuration, used only to plant patterns in images.
    logic [DATA_W-1:0] cfg_pat [PAT_REGS];
    logic [CARE_W-1:0] cfg_care;
    int                cfg_span;

    mbps_in_if  byte_if ();
    mbps_out_if res_if ();

    masked_byte_pattern_scan #(
        .PATTERN_MAX (PATTERN_MAX)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .byte_in    (byte_if),
        .result_out (res_if)
    );

    mbps_scan_checker #(
        .PATTERN_MAX (PATTERN_MAX)
    ) scan_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .byte_mon   (byte_if),
        .result_mon (res_if),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("masked_byte_pattern_scan regression: fail");
        $finish;
    end

    // Result receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // One register write: setup phase, access phase, then an idle phase.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << ADDR_LSB;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Writes every register; unused upper bits carry noise.
    task automatic configure(input logic [DATA_W-1:0] words [PAT_REGS],
                             input logic [CARE_W-1:0] care, input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] junk;
        write_reg(REG_PAT0, words[0]);
        write_reg(REG_PAT1, words[1]);
        write_reg(REG_PAT2, words[2]);
        write_reg(REG_PAT3, words[3]);
        junk = {$urandom, $urandom};
        junk[CARE_W-1:0] = care;
        write_reg(REG_CARE, junk);
        junk = {$urandom, $urandom};
        junk[LEN_W-1:0] = len;
        write_reg(REG_LEN, junk);
        cfg_pat  = words;
        cfg_care = care;
        cfg_span = (len > LEN_W'(PATTERN_MAX)) ? PATTERN_MAX : int'(len);
    endtask

    // Offers one word, after a random gap, and holds it until it is taken.
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_if.valid <= 1'b0;
            @(negedge clk);
        end
        byte_if.valid        <= 1'b1;
        byte_if.data_byte    <= data;
        byte_if.end_of_image <= last;
        do @(posedge clk); while (!byte_if.ready);
        @(negedge clk);
    endtask

    task automatic send_image(input logic [7:0] img [$]);
        foreach (img[i])
            send_byte(img[i], i == img.size() - 1);
    endtask

    // Stops offering and waits until every predicted result is out.
    task automatic settle();
        byte_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [7:0]        img [$];
        logic [DATA_W-1:0] words [PAT_REGS];
        logic [DATA_W-1:0] dir_words [PAT_REGS];
        logic [CARE_W-1:0] care;
        int                len_choice [PHASES];
        int                mode;
        int                phase_items;
        int                n;
        int                pos;
        int                pick;
        int                draw;
        bit                paused;

        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        byte_if.valid        = 1'b0;
        byte_if.data_byte    = '0;
        byte_if.end_of_image = 1'b0;
        res_if.ready         = 1'b0;
        hold_request         = 1'b0;
        hold_left            = 0;
        send_idle_pct        = 0;
        recv_idle_pct        = 0;
        cfg_care             = '0;
        cfg_span             = 0;
        foreach (cfg_pat[i]) cfg_pat[i] = '0;
        rst_n                = 1'b0;
        len_choice = '{1, 3, 63, 0, 32, 45, 2, 16, 0, 33, 5, 31};

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Writes past the register list must leave the zero length in place.
        write_reg(REG_SPARE0, '1);
        write_reg(REG_SPARE1, {$urandom, $urandom});

        // Zero length: each image matches at offset 0 on its first byte, nothing more.
        img = '{8'h00, 8'hFF};
        send_image(img);
        img = '{8'h80};
        send_image(img);
        settle();

        // Three-byte pattern, care bits beyond the length set.
        dir_words = '{{40'h0, 8'h00, 8'hFF, CHAR_X}, '0, '0, '0};
        configure(dir_words, '1, 3);
        img = '{CHAR_X, 8'hFF, 8'h00};
        send_image(img);
        img = '{8'h00, CHAR_X, 8'hFF, 8'h00, CHAR_X, 8'hFF, 8'h00};
        send_image(img);
        img = '{CHAR_X, 8'hFF};
        send_image(img);
        img = '{CHAR_X, 8'hFE, 8'h00};
        send_image(img);
        settle();

        // Middle byte is a wildcard.
        configure(dir_words, 32'h5, 3);
        img = '{CHAR_X, 8'h12, 8'h00};
        send_image(img);
        settle();

        // One-byte patterns, wildcard and exact.
        configure(dir_words, '0, 1);
        img = '{8'hAB};
        send_image(img);
        settle();
        configure(dir_words, 32'h1, 1);
        img = '{8'h01, CHAR_X};
        send_image(img);

        // Random phases: sender idles lightly, then the receiver, then neither.
        for (int q = 0; q < PHASES; q++)
        begin
            settle();
            mode = q / 4;
            send_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 83 : 0;
            recv_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 6 : 0;

            foreach (words[i])
            begin
                if (q == 0)
                    words[i] = '1;
                else if (q == 6)
                    words[i] = '0;
                else if (q % 3 == 1)
                    words[i] = X_FILL;
                else
                    words[i] = {$urandom, $urandom};
            end
            case (q % 4)
                0:       care = '1;
                1:       care = $urandom;
                2:       care = $urandom & $urandom & $urandom;
                default: care = '0;
            endcase
            configure(words, care, LEN_W'(len_choice[q]));

            // The receiver holds off while the sender keeps offering words.
            if (q == HOLD_PHASE)
            begin
                @(posedge clk);
                hold_request = 1'b1;
                @(negedge clk);
            end

            phase_items = 0;
            paused = 1'b0;
            while (phase_items < PHASE_WORDS)
            begin
                // Mostly images with the pattern planted, some spoiled, some pure noise.
                draw = $urandom_range(99);
                if (draw < 80)
                    n = cfg_span + $urandom_range(0, 10);
                else
                    n = $urandom_range(1, 20);
                if (n == 0)
                    n = 1;
                img.delete();
                for (int j = 0; j < n; j++)
                    img.push_back(($urandom_range(3) == 0) ? CHAR_X : 8'($urandom_range(255)));
                if (draw < 80 && cfg_span > 0)
                begin
                    pos = $urandom_range(0, n - cfg_span);
                    for (int j = 0; j < cfg_span; j++)
                        if (cfg_care[j])
                            img[pos + j] = cfg_pat[j / 8][(j % 8) * 8 +: 8];
                    if (draw >= 60)
                    begin
                        pick = $urandom_range(0, cfg_span - 1);
                        if (cfg_care[pick])
                            img[pos + pick] ^= 8'(1 << $urandom_range(0, 7));
                    end
                end
                send_image(img);
                phase_items += n;

                // Once, the sender waits mid-phase for the block to drain.
                if (q == PAUSE_PHASE && !paused && phase_items >= PHASE_WORDS / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        settle();
        repeat (10) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("masked_byte_pattern_scan regression: pass");
        else
            $display("masked_byte_pattern_scan regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_in_if.sv
hw/rtl/mbps_out_if.sv
hw/rtl/mbps_cfg.sv
hw/rtl/mbps_match.sv
hw/rtl/masked_byte_pattern_scan.sv
dv/mbps_scan_checker.sv
dv/tb_masked_byte_pattern_scan.sv
